/* src/bbf_pkg.sv */
// ----------------------------------------------------------------------------
// Box blur frame filter package
// Shared widths, register indexes, command and window mode codes.
// ----------------------------------------------------------------------------
package bbf_pkg;

  localparam int COORD_W    = 8;
  localparam int RAD_W      = 6;
  localparam int COLOR_W    = 8;
  localparam int PIX_W      = 3 * COLOR_W;
  localparam int SUM_W      = 24;
  localparam int CNT_W      = 16;
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int MODE_W     = 2;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MODE  = 2'd3;

  localparam logic [MODE_W-1:0] MODE_BOX   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HORIZ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VERT  = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

endpackage

/* src/bbf_frame_mem.sv */
// ----------------------------------------------------------------------------
// Frame store
// Single write port and single read port pixel memory with registered read.
// ----------------------------------------------------------------------------
module bbf_frame_mem #(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         waddr_i,
  input  logic [bbf_pkg::PIX_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]         raddr_i,
  output logic [bbf_pkg::PIX_W-1:0] rdata_o
);
  import bbf_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/bbf_divider.sv */
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbf_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bbf_pkg::sum_t       dividend_i,
  input  bbf_pkg::cnt_t       divisor_i,
  output logic                done_o,
  output bbf_pkg::color_t     quotient_o
);
  import bbf_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  cnt_t              rem_q, rem_d;
  sum_t              quo_q, quo_d;
  cnt_t              dvs_q, dvs_d;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    dvs_ext;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    rem_sh  = {rem_q, quo_q[SUM_W-1]};
    dvs_ext = {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= dvs_ext) begin
        rem_d = CNT_W'(rem_sh - dvs_ext);
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = CNT_W'(rem_sh);
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[COLOR_W-1:0];

endmodule

/* src/box_blur_frame_filter_unit.sv */
// ----------------------------------------------------------------------------
// Box blur frame filter unit
// Stores an RGB frame and returns clipped window means per color.
// ----------------------------------------------------------------------------
// A write item leaves the block idle and ready for the next item. A read item
// inside the frame keeps further items out until its result is handed on. The
// single read port of the frame store delivers one pixel per cycle of the
// clipped window to the accumulators, the drain state empties the read
// pipeline, and one restoring divider then computes each of the three means
// in turn, one quotient bit per cycle. The done state hands the result to the
// output register. An out-of-frame read goes straight to the done state. A
// finished result waits in an output register, and a new item is taken while it
// waits. A further result waits in the block until the output register is free.
module box_blur_frame_filter_unit #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_RADIUS = 63
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bbf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bbf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [6:0]                     column_i,
  input  logic [6:0]                     row_i,
  input  bbf_pkg::color_t                red_in_i,
  input  bbf_pkg::color_t                green_in_i,
  input  bbf_pkg::color_t                blue_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bbf_pkg::color_t                red_out_o,
  output bbf_pkg::color_t                green_out_o,
  output bbf_pkg::color_t                blue_out_o,
  output logic                           status_o
);
  import bbf_pkg::*;

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WCAP_I  = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
  localparam int HCAP_I  = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
  localparam int RCAP_I  = (MAX_RADIUS > 63) ? 63 : MAX_RADIUS;
  localparam logic [COORD_W-1:0] WCAP = COORD_W'(WCAP_I);
  localparam logic [COORD_W-1:0] HCAP = COORD_W'(HCAP_I);
  localparam logic [RAD_W-1:0]   RCAP = RAD_W'(RCAP_I);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [COORD_W-1:0]    fwidth_q, fheight_q;
  logic [RAD_W-1:0]      radius_q;
  logic [MODE_W-1:0]     mode_q;

  logic [2:0]            state_q;
  logic [COORD_W-1:0]    x_q, y_q, c0_q, c1_q, r1_q;
  logic                  pend_q;
  sum_t                  sum_r_q, sum_g_q, sum_b_q;
  cnt_t                  cnt_q;
  logic [1:0]            color_q;
  logic                  start_q;
  color_t                res_r_q, res_g_q, res_b_q;
  logic                  res_st_q;
  logic                  out_valid_q;
  color_t                out_r_q, out_g_q, out_b_q;
  logic                  out_st_q;

  logic [COORD_W-1:0]    w_eff, h_eff, col_ext, row_ext;
  logic [RAD_W-1:0]      r_eff, rr, cr;
  logic [COORD_W:0]      c_sum, r_sum;
  logic [COORD_W-1:0]    c_lo, c_hi, r_lo, r_hi;
  logic                  pix_in_frame;
  logic                  in_acc;
  logic                  mem_we;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [PIX_W-1:0]      rdata;
  sum_t                  dividend;
  logic                  div_done;
  color_t                quotient;
  logic                  out_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwidth_q  <= 8'd128;
      fheight_q <= 8'd128;
      radius_q  <= 6'd1;
      mode_q    <= MODE_BOX;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  fwidth_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: fheight_q <= cfg_data_i;
        CFG_BLUR_RADIUS:  radius_q  <= cfg_data_i[RAD_W-1:0];
        CFG_WINDOW_MODE:  mode_q    <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff   = (fwidth_q > WCAP) ? WCAP : fwidth_q;
    h_eff   = (fheight_q > HCAP) ? HCAP : fheight_q;
    r_eff   = (radius_q > RCAP) ? RCAP : radius_q;
    rr      = (mode_q == MODE_HORIZ) ? '0 : r_eff;
    cr      = (mode_q == MODE_VERT) ? '0 : r_eff;
    col_ext = {1'b0, column_i};
    row_ext = {1'b0, row_i};
    pix_in_frame = (col_ext < w_eff) && (row_ext < h_eff);
    c_lo    = (col_ext > COORD_W'(cr)) ? col_ext - COORD_W'(cr) : '0;
    r_lo    = (row_ext > COORD_W'(rr)) ? row_ext - COORD_W'(rr) : '0;
    c_sum   = {1'b0, col_ext} + (COORD_W + 1)'(cr);
    r_sum   = {1'b0, row_ext} + (COORD_W + 1)'(rr);
    c_hi    = (c_sum > {1'b0, w_eff - 1'b1}) ? w_eff - 1'b1 : c_sum[COORD_W-1:0];
    r_hi    = (r_sum > {1'b0, h_eff - 1'b1}) ? h_eff - 1'b1 : r_sum[COORD_W-1:0];
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign mem_we     = in_acc && (cmd_i == CMD_WRITE) && pix_in_frame;
  assign waddr      = ADDR_W'(ADDR_W'(row_ext) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_ext));
  assign raddr      = ADDR_W'(ADDR_W'(y_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_q));

  bbf_frame_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i ({red_in_i, green_in_i, blue_in_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    case (color_q)
      2'd0:    dividend = sum_r_q;
      2'd1:    dividend = sum_g_q;
      default: dividend = sum_b_q;
    endcase
  end

  bbf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (dividend),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      start_q <= 1'b0;
      color_q <= '0;
    end else begin
      pend_q  <= (state_q == ST_SCAN);
      start_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (cmd_i == CMD_READ)) begin
            state_q <= pix_in_frame ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          if ((x_q == c1_q) && (y_q == r1_q)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_DIV;
          start_q <= 1'b1;
          color_q <= '0;
        end
        ST_DIV: begin
          if (div_done) begin
            if (color_q == 2'd2) begin
              state_q <= ST_DONE;
            end else begin
              color_q <= color_q + 1'b1;
              start_q <= 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (cmd_i == CMD_READ)) begin
      x_q      <= c_lo;
      c0_q     <= c_lo;
      c1_q     <= c_hi;
      y_q      <= r_lo;
      r1_q     <= r_hi;
      sum_r_q  <= '0;
      sum_g_q  <= '0;
      sum_b_q  <= '0;
      cnt_q    <= '0;
      res_r_q  <= '0;
      res_g_q  <= '0;
      res_b_q  <= '0;
      res_st_q <= !pix_in_frame;
    end else begin
      if (state_q == ST_SCAN) begin
        if (x_q == c1_q) begin
          x_q <= c0_q;
          y_q <= y_q + 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      if (pend_q) begin
        sum_r_q <= sum_r_q + SUM_W'(rdata[PIX_W-1 -: COLOR_W]);
        sum_g_q <= sum_g_q + SUM_W'(rdata[COLOR_W +: COLOR_W]);
        sum_b_q <= sum_b_q + SUM_W'(rdata[COLOR_W-1:0]);
        cnt_q   <= cnt_q + 1'b1;
      end
      if ((state_q == ST_DIV) && div_done) begin
        case (color_q)
          2'd0:    res_r_q <= quotient;
          2'd1:    res_g_q <= quotient;
          default: res_b_q <= quotient;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_r_q  <= res_r_q;
      out_g_q  <= res_g_q;
      out_b_q  <= res_b_q;
      out_st_q <= res_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_r_q;
  assign green_out_o = out_g_q;
  assign blue_out_o  = out_b_q;
  assign status_o    = out_st_q;

  a_status_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> (red_out_o == '0) && (green_out_o == '0) &&
                                (blue_out_o == '0))
    else $error("Out-of-frame result carries nonzero colors.");

  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> (cnt_q != '0))
    else $error("Division started with an empty window.");

  a_read_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CMD_READ) |=> !in_ready_o)
    else $error("Input ready did not drop after a read item.");

endmodule

/* dv/tb_box_blur_frame_filter_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box blur frame filter unit testbench
// Directed tests cover window clipping at the frame edges, the box,
// horizontal, vertical and unused window modes, out-of-frame reads and
// writes, empty and oversized frames and resizing over stored pixels. Random
// traffic then runs under several idle and stall patterns. A frame model in
// the testbench predicts every read result, and a checker compares each
// result with the oldest prediction. Reads only cover pixels already written.
// ----------------------------------------------------------------------------
module tb_box_blur_frame_filter_unit;
  import bbf_pkg::*;

  localparam int FRAME_MAX     = 128;
  localparam int REGION        = 5;
  localparam logic [7:0] REGION_SIZE = 8'(REGION);
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 200;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
    logic   status;
  } blur_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  cmd = CMD_WRITE;
  logic [6:0]            column = '0;
  logic [6:0]            row = '0;
  color_t                red_in = '0;
  color_t                green_in = '0;
  color_t                blue_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  color_t                red_out;
  color_t                green_out;
  color_t                blue_out;
  logic                  status;

  logic [PIX_W-1:0] frame_px [FRAME_MAX][FRAME_MAX];
  bit               written_px [FRAME_MAX][FRAME_MAX];
  logic [7:0]       cfg_w = 8'd128;
  logic [7:0]       cfg_h = 8'd128;
  logic [5:0]       cfg_rad = 6'd1;
  logic [1:0]       cfg_mode = MODE_BOX;

  blur_result_t blur_expect_q[$];
  blur_result_t want_res;
  int error_count = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  box_blur_frame_filter_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .column_i    (column),
    .row_i       (row),
    .red_in_i    (red_in),
    .green_in_i  (green_in),
    .blue_in_i   (blue_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .red_out_o   (red_out),
    .green_out_o (green_out),
    .blue_out_o  (blue_out),
    .status_o    (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int eff_width();
    return (cfg_w > FRAME_MAX) ? FRAME_MAX : int'(cfg_w);
  endfunction

  function automatic int eff_height();
    return (cfg_h > FRAME_MAX) ? FRAME_MAX : int'(cfg_h);
  endfunction

  function automatic bit in_frame(input int col, input int rw);
    return col < eff_width() && rw < eff_height();
  endfunction

  function automatic void window_bounds(input int col, input int rw,
                                        output int r0, output int r1,
                                        output int c0, output int c1);
    int rad_r;
    int rad_c;
    rad_r = (cfg_mode == MODE_HORIZ) ? 0 : int'(cfg_rad);
    rad_c = (cfg_mode == MODE_VERT) ? 0 : int'(cfg_rad);
    r0 = (rw - rad_r < 0) ? 0 : rw - rad_r;
    r1 = (rw + rad_r > eff_height() - 1) ? eff_height() - 1 : rw + rad_r;
    c0 = (col - rad_c < 0) ? 0 : col - rad_c;
    c1 = (col + rad_c > eff_width() - 1) ? eff_width() - 1 : col + rad_c;
  endfunction

  function automatic bit read_is_safe(input int col, input int rw);
    int r0, r1, c0, c1;
    if (!in_frame(col, rw)) return 1'b1;
    window_bounds(col, rw, r0, r1, c0, c1);
    for (int y = r0; y <= r1; y++) begin
      for (int x = c0; x <= c1; x++) begin
        if (!written_px[y][x]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_blur(input logic op, input int col, input int rw,
                                       input color_t r, input color_t g,
                                       input color_t b);
    int r0, r1, c0, c1;
    int unsigned sr, sg, sb, n;
    blur_result_t res;
    sr = 0;
    sg = 0;
    sb = 0;
    n = 0;
    if (op == CMD_WRITE) begin
      if (in_frame(col, rw)) begin
        frame_px[rw][col] = {r, g, b};
        written_px[rw][col] = 1'b1;
      end
      return;
    end
    if (!in_frame(col, rw)) begin
      res = '{red: '0, green: '0, blue: '0, status: 1'b1};
    end else begin
      window_bounds(col, rw, r0, r1, c0, c1);
      for (int y = r0; y <= r1; y++) begin
        for (int x = c0; x <= c1; x++) begin
          sr += frame_px[y][x][23:16];
          sg += frame_px[y][x][15:8];
          sb += frame_px[y][x][7:0];
          n++;
        end
      end
      if (n == 0) n = 1;
      res.red = color_t'(sr / n);
      res.green = color_t'(sg / n);
      res.blue = color_t'(sb / n);
      res.status = 1'b0;
    end
    blur_expect_q.push_back(res);
  endfunction

  function automatic color_t rand_color();
    return color_t'($urandom_range(0, 255));
  endfunction

  function automatic logic [6:0] pick_coord();
    if ($urandom_range(99) < 70) return 7'($urandom_range(0, REGION + 1));
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (blur_expect_q.size() == 0) begin
        report_mismatch("result with no read pending");
      end else begin
        want_res = blur_expect_q.pop_front();
        check_field("red", red_out, want_res.red);
        check_field("green", green_out, want_res.green);
        check_field("blue", blue_out, want_res.blue);
        check_field("status", {7'd0, status}, {7'd0, want_res.status});
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic op, input logic [6:0] col, input logic [6:0] rw,
                           input color_t r, input color_t g, input color_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    column <= col;
    row <= rw;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_blur(op, col, rw, r, g, b);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (blur_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH:  cfg_w = data;
      CFG_FRAME_HEIGHT: cfg_h = data;
      CFG_BLUR_RADIUS:  cfg_rad = data[5:0];
      CFG_WINDOW_MODE:  cfg_mode = data[1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] w, input logic [7:0] h,
                           input logic [5:0] rad, input logic [1:0] mode);
    settle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_BLUR_RADIUS, {2'b00, rad});
    write_reg(CFG_WINDOW_MODE, {6'd0, mode});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic read_at(input logic [6:0] col, input logic [6:0] rw);
    send_item(CMD_READ, col, rw, rand_color(), rand_color(), rand_color());
  endtask

  task automatic test_fill_region();
    int x, y;
    configure(REGION_SIZE, REGION_SIZE, 1, MODE_BOX);
    for (y = 0; y < REGION; y++) begin
      for (x = 0; x < REGION; x++) begin
        if (x == 0 && y == 0) begin
          send_item(CMD_WRITE, 7'(x), 7'(y), 8'hFF, 8'hFF, 8'hFF);
        end else if (x == 1 && y == 0) begin
          send_item(CMD_WRITE, 7'(x), 7'(y), 8'h00, 8'h00, 8'h00);
        end else begin
          send_item(CMD_WRITE, 7'(x), 7'(y), rand_color(), rand_color(), rand_color());
        end
      end
    end
  endtask

  task automatic test_box_window();
    configure(REGION_SIZE, REGION_SIZE, 1, MODE_BOX);
    read_at(7'd0, 7'd0);
    read_at(7'd4, 7'd4);
    read_at(7'd2, 7'd2);
    configure(REGION_SIZE, REGION_SIZE, 0, MODE_BOX);
    read_at(7'd0, 7'd0);
    read_at(7'd1, 7'd0);
    configure(REGION_SIZE, REGION_SIZE, 63, MODE_BOX);
    read_at(7'd2, 7'd3);
  endtask

  task automatic test_line_modes();
    configure(REGION_SIZE, REGION_SIZE, 2, MODE_HORIZ);
    read_at(7'd0, 7'd2);
    read_at(7'd4, 7'd1);
    configure(REGION_SIZE, REGION_SIZE, 2, MODE_VERT);
    read_at(7'd3, 7'd4);
    configure(REGION_SIZE, REGION_SIZE, 1, MODE_SPARE);
    read_at(7'd2, 7'd2);
  endtask

  task automatic test_out_of_frame();
    configure(REGION_SIZE, REGION_SIZE, 1, MODE_BOX);
    read_at(7'd5, 7'd0);
    read_at(7'd0, 7'd5);
    read_at(7'd127, 7'd127);
    send_item(CMD_WRITE, 7'd127, 7'd0, rand_color(), rand_color(), rand_color());
    configure(1, 1, 63, MODE_VERT);
    read_at(7'd0, 7'd0);
    read_at(7'd0, 7'd1);
  endtask

  task automatic test_resize();
    configure(6, 1, 0, MODE_BOX);
    send_item(CMD_WRITE, 7'd5, 7'd0, 8'h12, 8'h34, 8'h56);
    configure(5, 1, 0, MODE_BOX);
    send_item(CMD_WRITE, 7'd5, 7'd0, 8'hAA, 8'hBB, 8'hCC);
    read_at(7'd5, 7'd0);
    configure(0, 5, 0, MODE_BOX);
    read_at(7'd0, 7'd0);
    send_item(CMD_WRITE, 7'd0, 7'd0, 8'h01, 8'h02, 8'h03);
    configure(5, 0, 0, MODE_BOX);
    read_at(7'd3, 7'd3);
    send_item(CMD_WRITE, 7'd1, 7'd1, 8'h04, 8'h05, 8'h06);
    configure(6, 5, 0, MODE_HORIZ);
    read_at(7'd5, 7'd0);
    read_at(7'd0, 7'd0);
    read_at(7'd1, 7'd1);
  endtask

  task automatic test_large_frame();
    configure(255, 200, 1, MODE_BOX);
    send_item(CMD_WRITE, 7'd126, 7'd126, rand_color(), rand_color(), rand_color());
    send_item(CMD_WRITE, 7'd127, 7'd126, rand_color(), rand_color(), rand_color());
    send_item(CMD_WRITE, 7'd126, 7'd127, rand_color(), rand_color(), rand_color());
    send_item(CMD_WRITE, 7'd127, 7'd127, 8'h7F, 8'h80, 8'h01);
    read_at(7'd127, 7'd127);
    configure(128, 128, 0, MODE_VERT);
    read_at(7'd126, 7'd127);
    read_at(7'd127, 7'd127);
  endtask

  task automatic test_backpressure();
    configure(REGION_SIZE, REGION_SIZE, 63, MODE_BOX);
    @(posedge clk);
    hold_cycles = 300;
    repeat (10) read_at(7'($urandom_range(0, REGION - 1)), 7'($urandom_range(0, REGION - 1)));
    settle();
  endtask

  function automatic logic [7:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      8: return 8'd128;
      9: return 8'd255;
      default: return 8'($urandom_range(2, REGION));
    endcase
  endfunction

  task automatic random_item();
    logic [6:0] col, rw;
    bit found;
    found = 1'b0;
    if ($urandom_range(99) < 60) begin
      for (int tries = 0; tries < 50 && !found; tries++) begin
        col = pick_coord();
        rw = pick_coord();
        found = read_is_safe(col, rw);
      end
      if (found) begin
        read_at(col, rw);
        return;
      end
    end
    send_item(CMD_WRITE, pick_coord(), pick_coord(), rand_color(), rand_color(), rand_color());
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall);
    logic [7:0] w, h;
    logic [5:0] rad;
    send_gap_pct = gap_pct;
    stall_pct = stall;
    repeat (2) begin
      w = pick_size();
      h = pick_size();
      rad = ($urandom_range(1) == 0) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
      if (w >= FRAME_MAX && h >= FRAME_MAX) rad = 6'($urandom_range(0, 2));
      configure(w, h, rad, 2'($urandom_range(0, 3)));
      repeat (4) random_item();
    end
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_fill_region();
    test_box_window();
    test_line_modes();
    test_out_of_frame();
    test_resize();
    test_large_frame();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(47, 0);
    test_random_traffic(0, 47);
    test_random_traffic(35, 35);
    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
src/bbf_pkg.sv
src/bbf_frame_mem.sv
src/bbf_divider.sv
src/box_blur_frame_filter_unit.sv
dv/tb_box_blur_frame_filter_unit.sv
